### sv/srts_pkg.sv
// ----------------------------------------------------------------------------
// srts_pkg: shared definitions for the shortest-remaining-time scheduler
// Field widths of the channels, parameter defaults, function codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package srts_pkg;

  // Default sizing of the task table and the time counter.
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int SLOT_W  = 4;
  localparam int FIELD_W = 16;
  localparam int CFG_W   = 5;

  // Function codes carried by an input transaction.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_WRAP,
    ST_LDOUT
  } state_t;

endpackage

### sv/srts_in_if.sv
// ----------------------------------------------------------------------------
// srts_in_if: input channel of the scheduler
// Valid/ready channel carrying one load or tick request per transaction.
// ----------------------------------------------------------------------------
interface srts_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [srts_pkg::SLOT_W-1:0]   slot;
  logic [srts_pkg::FIELD_W-1:0]  arrival;
  logic [srts_pkg::FIELD_W-1:0]  burst;

  modport source (output valid, func, slot, arrival, burst, input ready);
  modport sink   (input valid, func, slot, arrival, burst, output ready);
endinterface

### sv/srts_out_if.sv
// ----------------------------------------------------------------------------
// srts_out_if: result channel of the scheduler
// Valid/ready channel carrying one scheduling report per transaction.
// ----------------------------------------------------------------------------
interface srts_out_if;
  logic                          valid;
  logic                          ready;
  logic [srts_pkg::SLOT_W-1:0]   running_slot;
  logic                          idle;
  logic                          new_segment;
  logic                          finished;
  logic [srts_pkg::FIELD_W-1:0]  completion_time;
  logic [srts_pkg::FIELD_W-1:0]  turnaround;
  logic [srts_pkg::FIELD_W-1:0]  waiting;
  logic                          all_done;

  modport source (output valid, running_slot, idle, new_segment, finished,
                  completion_time, turnaround, waiting, all_done, input ready);
  modport sink   (input valid, running_slot, idle, new_segment, finished,
                  completion_time, turnaround, waiting, all_done, output ready);
endinterface

### sv/shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler: preemptive SRTF task scheduler
// Task table in small memories, scanned by one shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per request. A load (func 0) writes the
//   arrival and burst of one slot and restarts the schedule; a tick (func 1)
//   picks the arrived, unfinished counted slot with the least remaining
//   time, runs it for one time unit and advances the clock.
//   out_ch returns exactly one report per accepted request.
//   cfg_we/cfg_wdata set task_count, the number of slots that take part.
// Timing:
//   A tick scans the task_count slots, clamped to MAX_TASKS: the slots are
//   read one per cycle from the table memories and fed through a single
//   compare unit, followed by an update state and a report state. A load
//   goes straight to its report state. in_ch.ready is high only in the
//   idle state, so the next request is accepted only once the report of
//   the last one has been registered.
// Reset:
//   Synchronous, active low. The schedule restarts and task_count becomes
//   1; table contents stay undefined until loaded. No clearing pass.
// Stall:
//   While out_ch.ready is low the report holds in the output register; a
//   following request is still accepted and waits in its report cycle.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler #(
  parameter int MAX_TASKS = srts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = srts_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  srts_in_if.sink                   in_ch,
  srts_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [srts_pkg::CFG_W-1:0] cfg_wdata
);
  import srts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SLW_W = (SLOT_W > 32) ? SLOT_W : 32;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);
  localparam logic [CNT_W-1:0]     CNT_ONE  = CNT_W'(1);

  // Table memories.
  logic [TIME_BITS-1:0] arrival_mem   [MAX_TASKS];
  logic [TIME_BITS-1:0] burst_mem     [MAX_TASKS];
  logic [TIME_BITS-1:0] remaining_mem [MAX_TASKS];

  // Control and datapath registers.
  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     task_count_r;
  logic [CNT_W-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 best_found_r, best_found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_rem_r, best_rem_nxt;
  logic [TIME_BITS-1:0] best_arr_r, best_arr_nxt;
  logic [TIME_BITS-1:0] best_bur_r, best_bur_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] done_r, done_nxt;
  logic [MAX_TASKS-1:0] rem_vld_r, rem_vld_nxt;
  logic                 last_vld_r, last_vld_nxt;
  logic                 last_idle_r, last_idle_nxt;
  logic [IDX_W-1:0]     last_slot_r, last_slot_nxt;
  logic                 seg_r, seg_nxt;
  logic                 fin_r, fin_nxt;
  logic [TIME_BITS-1:0] ct_r, ct_nxt;
  logic [TIME_BITS-1:0] tat_r, tat_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_load;

  // Output payload registers.
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_idle_r;
  logic                 out_seg_r;
  logic                 out_fin_r;
  logic [FIELD_W-1:0]   out_ct_r;
  logic [FIELD_W-1:0]   out_tat_r;
  logic [FIELD_W-1:0]   out_wt_r;
  logic                 out_all_r;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_idle;
  logic                 res_seg;
  logic                 res_fin;
  logic [TIME_BITS-1:0] res_ct;
  logic [TIME_BITS-1:0] res_tat;
  logic [TIME_BITS-1:0] res_wt;
  logic                 res_all;

  // Memory read stage and write controls.
  logic [IDX_W-1:0]     rd_addr;
  logic [TIME_BITS-1:0] rd_arr_r, rd_bur_r, rd_rem_r;
  logic                 ld_we;
  logic [IDX_W-1:0]     ld_addr;
  logic                 rem_we;
  logic [TIME_BITS-1:0] rem_wdata;

  // Scan and update helpers.
  logic [CNT_W-1:0]     n_cnt;
  logic                 in_acc;
  logic                 slot_ok;
  logic [TIME_BITS-1:0] cur_rem;
  logic                 eligible;
  logic                 better;
  logic [TIME_BITS-1:0] time_inc;
  logic [TIME_BITS-1:0] rem_dec;

  // Number of counted slots: task_count clamped to the table depth.
  always_comb begin
    if (CMP_W'(task_count_r) > CMP_W'(MAX_TASKS)) begin
      n_cnt = CNT_W'(MAX_TASKS);
    end else begin
      n_cnt = CNT_W'(task_count_r);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_ok     = (SLW_W'(in_ch.slot) < SLW_W'(MAX_TASKS));
  assign ld_addr     = IDX_W'(in_ch.slot);
  assign ld_we       = in_acc && (in_ch.func == FUNC_LOAD) && slot_ok;
  assign rd_addr     = issue_cnt_r[IDX_W-1:0];

  // Shared compare unit: the remaining time of a slot that has not run
  // since the last restart is its burst.
  assign cur_rem  = rem_vld_r[cmp_idx_r] ? rd_rem_r : rd_bur_r;
  assign eligible = !done_r[cmp_idx_r] && (cur_rem != '0) && (rd_arr_r <= time_r);
  assign better   = !best_found_r || (cur_rem < best_rem_r) ||
                    ((cur_rem == best_rem_r) && (rd_arr_r < best_arr_r));

  assign time_inc = (time_r == TIME_MAX) ? time_r : (time_r + TIME_ONE);
  assign rem_dec  = best_rem_r - TIME_ONE;

  // Report fields as formed in the report cycle.
  assign res_slot = SLOT_W'(best_idx_r);
  assign res_idle = !best_found_r;
  assign res_seg  = seg_r;
  assign res_fin  = fin_r;
  assign res_ct   = ct_r;
  assign res_tat  = tat_r;
  assign res_wt   = (fin_r && (tat_r >= best_bur_r)) ? (tat_r - best_bur_r) : '0;
  assign res_all  = (count_r >= n_cnt);

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_nxt      = state_r;
    issue_cnt_nxt  = issue_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_rem_nxt   = best_rem_r;
    best_arr_nxt   = best_arr_r;
    best_bur_nxt   = best_bur_r;
    time_nxt       = time_r;
    count_nxt      = count_r;
    done_nxt       = done_r;
    rem_vld_nxt    = rem_vld_r;
    last_vld_nxt   = last_vld_r;
    last_idle_nxt  = last_idle_r;
    last_slot_nxt  = last_slot_r;
    seg_nxt        = seg_r;
    fin_nxt        = fin_r;
    ct_nxt         = ct_r;
    tat_nxt        = tat_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_load       = 1'b0;
    rem_we         = 1'b0;
    rem_wdata      = rem_dec;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_LOAD) begin
            // A load into a valid slot restarts the schedule.
            if (slot_ok) begin
              time_nxt    = '0;
              count_nxt   = '0;
              done_nxt    = '0;
              rem_vld_nxt = '0;
              last_vld_nxt = 1'b0;
            end
            best_found_nxt = 1'b0;
            best_idx_nxt   = '0;
            state_nxt      = ST_LDOUT;
          end else begin
            best_found_nxt = 1'b0;
            best_idx_nxt   = '0;
            issue_cnt_nxt  = '0;
            state_nxt      = (n_cnt == '0) ? ST_UPD : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one slot read per cycle; compare the slot read last cycle.
        if (issue_cnt_r < n_cnt) begin
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = rd_addr;
          issue_cnt_nxt = issue_cnt_r + CNT_ONE;
        end
        if (cmp_vld_r && eligible && better) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = cmp_idx_r;
          best_rem_nxt   = cur_rem;
          best_arr_nxt   = rd_arr_r;
          best_bur_nxt   = rd_bur_r;
        end
        if ((issue_cnt_r == n_cnt) && cmp_vld_r) begin
          state_nxt = ST_UPD;
        end
      end

      ST_UPD: begin
        // Run the chosen task for one unit and advance time.
        time_nxt = time_inc;
        fin_nxt  = 1'b0;
        ct_nxt   = '0;
        tat_nxt  = '0;
        if (best_found_r) begin
          rem_we                  = 1'b1;
          rem_vld_nxt[best_idx_r] = 1'b1;
          if (rem_dec == '0) begin
            done_nxt[best_idx_r] = 1'b1;
            count_nxt            = count_r + CNT_ONE;
            fin_nxt              = 1'b1;
            ct_nxt               = time_inc;
            tat_nxt              = time_inc - best_arr_r;
          end
          seg_nxt = !last_vld_r || last_idle_r || (last_slot_r != best_idx_r);
        end else begin
          seg_nxt = !last_vld_r || !last_idle_r;
        end
        last_vld_nxt  = 1'b1;
        last_idle_nxt = !best_found_r;
        last_slot_nxt = best_idx_r;
        state_nxt     = ST_WRAP;
      end

      ST_WRAP: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      ST_LDOUT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= CFG_W'(1);
      issue_cnt_r  <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      time_r       <= '0;
      count_r      <= '0;
      done_r       <= '0;
      rem_vld_r    <= '0;
      last_vld_r   <= 1'b0;
      last_idle_r  <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      best_found_r <= best_found_nxt;
      time_r       <= time_nxt;
      count_r      <= count_nxt;
      done_r       <= done_nxt;
      rem_vld_r    <= rem_vld_nxt;
      last_vld_r   <= last_vld_nxt;
      last_idle_r  <= last_idle_nxt;
      out_vld_r    <= out_vld_nxt;
      if (cfg_we) begin
        task_count_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_rem_r  <= best_rem_nxt;
    best_arr_r  <= best_arr_nxt;
    best_bur_r  <= best_bur_nxt;
    last_slot_r <= last_slot_nxt;
    seg_r       <= seg_nxt;
    fin_r       <= fin_nxt;
    ct_r        <= ct_nxt;
    tat_r       <= tat_nxt;
  end

  // Table memories: one write port each, registered reads for the scan.
  always_ff @(posedge clk) begin
    if (ld_we) begin
      arrival_mem[ld_addr] <= TIME_BITS'(in_ch.arrival);
      burst_mem[ld_addr]   <= TIME_BITS'(in_ch.burst);
    end
    if (rem_we) begin
      remaining_mem[best_idx_r] <= rem_wdata;
    end
    rd_arr_r <= arrival_mem[rd_addr];
    rd_bur_r <= burst_mem[rd_addr];
    rd_rem_r <= remaining_mem[rd_addr];
  end

  // Output register; a load reports idle with all other fields but all_done zero.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_LDOUT) begin
        out_slot_r <= '0;
        out_idle_r <= 1'b1;
        out_seg_r  <= 1'b0;
        out_fin_r  <= 1'b0;
        out_ct_r   <= '0;
        out_tat_r  <= '0;
        out_wt_r   <= '0;
      end else begin
        out_slot_r <= res_slot;
        out_idle_r <= res_idle;
        out_seg_r  <= res_seg;
        out_fin_r  <= res_fin;
        out_ct_r   <= FIELD_W'(res_ct);
        out_tat_r  <= FIELD_W'(res_tat);
        out_wt_r   <= FIELD_W'(res_wt);
      end
      out_all_r <= res_all;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.running_slot    = out_slot_r;
  assign out_ch.idle            = out_idle_r;
  assign out_ch.new_segment     = out_seg_r;
  assign out_ch.finished        = out_fin_r;
  assign out_ch.completion_time = out_ct_r;
  assign out_ch.turnaround      = out_tat_r;
  assign out_ch.waiting         = out_wt_r;
  assign out_ch.all_done        = out_all_r;

  // A slot can only be finished after it has run at least once.
  a_done_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & ~rem_vld_r) == '0)
    else $error("done flag set on a slot that never ran");

  // The completed count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(MAX_TASKS))
    else $error("completed count beyond table depth");

  // An accepted tick goes to the scan, or straight to update with no slots.
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.func == FUNC_TICK)) |=> (state_r == ST_SCAN || state_r == ST_UPD))
    else $error("tick did not start a scan");

  // The update cycle is always followed by the report cycle.
  a_upd_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (state_r == ST_WRAP))
    else $error("update not followed by report");

  // An idle report never carries a completion.
  a_idle_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_idle_r) |-> !out_fin_r)
    else $error("idle report flagged a completion");

endmodule
